@@ src/perspective_texture_blend_blit_macros.svh @@
// Assertion helpers shared by the blit RTL.
`ifndef PERSPECTIVE_TEXTURE_BLEND_BLIT_MACROS_SVH
`define PERSPECTIVE_TEXTURE_BLEND_BLIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define PTBB_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PTBB_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ptbb_pkg.sv @@
package ptbb_pkg;

    // Request commands
    localparam logic [1:0] CMD_LOAD_TEXEL = 2'd0;
    localparam logic [1:0] CMD_LOAD_COEF  = 2'd1;
    localparam logic [1:0] CMD_DRAW       = 2'd2;

    // Pixel formats
    localparam logic [1:0] FMT_RGB565   = 2'd0;
    localparam logic [1:0] FMT_RGB888   = 2'd1;
    localparam logic [1:0] FMT_ARGB8888 = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_OPACITY  = 3'd0;
    localparam logic [2:0] REG_SRC_W    = 3'd1;
    localparam logic [2:0] REG_SRC_H    = 3'd2;
    localparam logic [2:0] REG_SRC_FMT  = 3'd3;
    localparam logic [2:0] REG_DST_FMT  = 3'd4;

    localparam int MAX_SIDE_DEF = 64;
    localparam int COEF_NUM     = 9;
    // 32-bit coefficient times 11-bit signed coordinate, and a sum of three
    localparam int PROD_W       = 43;
    localparam int SUM_W        = 44;

    // Sideband that travels with every request through the pipeline
    typedef struct packed {
        logic [1:0]  cmd;
        logic [11:0] slot;
        logic [31:0] pay;
    } t_side;

    // Exact floor(n/255) for n up to 255*255
    function automatic logic [7:0] div255(input logic [15:0] n);
        logic [16:0] t;
        t = 17'(n) + 17'(n[15:8]) + 17'd1;
        return t[15:8];
    endfunction

endpackage

@@ src/perspective_texture_blend_blit.sv @@
// Throughput: one request per cycle unless output stalls; loads and draws use one pipeline.
// The depth is set by the restoring divider, one quotient bit per stage for X/Z and Y/Z.
// Texel store is a single-port sync RAM used in request order, one op per advancing cycle.
// Reset clears pipeline valid bits and the configuration registers (opacity 255,
// size 64x64, both formats RGB565); texel RAM and matrix hold no reset value.
`include "perspective_texture_blend_blit_macros.svh"

module perspective_texture_blend_blit #(
    parameter int MAX_SIDE = ptbb_pkg::MAX_SIDE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata,
    // request stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // slot[11:0], load_data[43:12], dest_x[53:44], dest_y[63:54], dest_pixel[95:64]
    input  logic [95:0] i_s_axis_tdata,
    // command[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // new_pixel[31:0]
    output logic [31:0] o_m_axis_tdata,
    // write_enable[0]
    output logic [0:0]  o_m_axis_tuser
);

    localparam int QB    = $clog2(MAX_SIDE);
    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int SWB   = $clog2(MAX_SIDE + 1);
    localparam int CW    = (SWB > 7) ? SWB : 7;
    localparam int PW    = ptbb_pkg::PROD_W;
    localparam int MW    = ptbb_pkg::SUM_W;
    localparam int DW    = MW + QB;
    localparam int S_OVF = 4;
    localparam int S_ADR = QB + 5;
    localparam int S_MEM = QB + 6;
    localparam int S_DEC = QB + 7;
    localparam int S_WGT = QB + 8;
    localparam int S_MIX = QB + 9;
    localparam int S_OUT = QB + 10;
    localparam int NS    = QB + 11;

    // configuration
    logic [7:0] r_opacity;
    logic [6:0] r_sw;
    logic [6:0] r_sh;
    logic [1:0] r_src_fmt;
    logic [1:0] r_dst_fmt;

    // pipeline control
    logic [NS-1:0]   r_vld;
    logic [NS-1:0]   en;
    ptbb_pkg::t_side r_side [NS];
    logic            acc;

    // stage data
    logic [31:0]           r_coef [ptbb_pkg::COEF_NUM];
    logic [9:0]            r_x0;
    logic [9:0]            r_y0;
    logic signed [PW-1:0]  r_p [6];
    logic signed [31:0]    r_c [3];
    logic signed [MW-1:0]  r_sx;
    logic signed [MW-1:0]  r_sy;
    logic signed [MW-1:0]  r_sz;
    logic [MW-1:0]         r_ax;
    logic [MW-1:0]         r_ay;
    logic [MW-1:0]         r_az;
    logic                  r_nx3;
    logic                  r_ny3;
    logic                  r_zz3;
    logic [DW-1:0]         r_rx [QB+1];
    logic [DW-1:0]         r_ry [QB+1];
    logic [MW-1:0]         r_zm [QB+1];
    logic [QB-1:0]         r_qx [QB+1];
    logic [QB-1:0]         r_qy [QB+1];
    logic                  r_ox [QB+1];
    logic                  r_oy [QB+1];
    logic                  r_nx [QB+1];
    logic                  r_ny [QB+1];
    logic                  r_zz [QB+1];
    logic [DW-1:0]         w_tz [1:QB];
    logic                  w_gx [1:QB];
    logic                  w_gy [1:QB];
    logic [AW-1:0]         r_addr;
    logic                  r_ahit;
    logic [31:0]           r_mem [DEPTH];
    logic [31:0]           r_rd;
    logic                  r_mhit;
    logic [7:0]            r_sc [4];
    logic [7:0]            r_dc [4];
    logic [15:0]           r_wp;
    logic                  r_dwe;
    logic [7:0]            r_wt;
    logic [7:0]            r_sc2 [4];
    logic [7:0]            r_dc2 [4];
    logic                  r_wwe;
    logic [15:0]           r_mx [4];
    logic                  r_mwe;
    logic [31:0]           r_opix;
    logic                  r_owe;

    // combinational
    logic [CW-1:0] w_wsat;
    logic [CW-1:0] w_hsat;
    logic          w_inx;
    logic          w_iny;
    logic [QB-1:0] w_xv;
    logic [QB-1:0] w_yv;
    logic [AW-1:0] w_daddr;
    logic          w_slot_ok;
    logic [7:0]    w_s [4];
    logic [7:0]    w_d [4];
    logic          w_key;
    logic          w_we;
    logic [7:0]    w_m [4];
    logic [31:0]   w_res;

    assign acc             = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = en[0];
    assign o_m_axis_tvalid = r_vld[S_OUT];
    assign o_m_axis_tdata  = r_opix;
    assign o_m_axis_tuser  = r_owe;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opacity <= 8'd255;
            r_sw      <= 7'd64;
            r_sh      <= 7'd64;
            r_src_fmt <= ptbb_pkg::FMT_RGB565;
            r_dst_fmt <= ptbb_pkg::FMT_RGB565;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ptbb_pkg::REG_OPACITY: r_opacity <= i_cfg_wdata;
                ptbb_pkg::REG_SRC_W:   r_sw      <= i_cfg_wdata[6:0];
                ptbb_pkg::REG_SRC_H:   r_sh      <= i_cfg_wdata[6:0];
                ptbb_pkg::REG_SRC_FMT: r_src_fmt <= i_cfg_wdata[1:0];
                ptbb_pkg::REG_DST_FMT: r_dst_fmt <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // stage advance: a stage moves when empty or when the next one moves
    always_comb begin
        en[NS-1] = !r_vld[NS-1] || i_m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    // valid bits; non-draw requests drop out at the output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NS - 1; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (en[S_OUT]) begin
                r_vld[S_OUT] <= r_vld[S_MIX] && (r_side[S_MIX].cmd == ptbb_pkg::CMD_DRAW);
            end
        end
    end

    // sideband shift
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_side[0].cmd  <= i_s_axis_tuser;
            r_side[0].slot <= i_s_axis_tdata[11:0];
            r_side[0].pay  <= (i_s_axis_tuser == ptbb_pkg::CMD_DRAW) ?
                              i_s_axis_tdata[95:64] : i_s_axis_tdata[43:12];
            r_x0           <= i_s_axis_tdata[53:44];
            r_y0           <= i_s_axis_tdata[63:54];
        end
        for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // matrix load at acceptance, ahead of any later draw's multiply
    always_ff @(posedge i_clk) begin
        if (acc && i_s_axis_tuser == ptbb_pkg::CMD_LOAD_COEF
                && i_s_axis_tdata[11:0] < 12'(ptbb_pkg::COEF_NUM)) begin
            r_coef[i_s_axis_tdata[3:0]] <= i_s_axis_tdata[43:12];
        end
    end

    // products, row sums, magnitudes
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_p[0] <= $signed(r_coef[0]) * $signed({1'b0, r_x0});
            r_p[1] <= $signed(r_coef[1]) * $signed({1'b0, r_y0});
            r_p[2] <= $signed(r_coef[3]) * $signed({1'b0, r_x0});
            r_p[3] <= $signed(r_coef[4]) * $signed({1'b0, r_y0});
            r_p[4] <= $signed(r_coef[6]) * $signed({1'b0, r_x0});
            r_p[5] <= $signed(r_coef[7]) * $signed({1'b0, r_y0});
            r_c[0] <= $signed(r_coef[2]);
            r_c[1] <= $signed(r_coef[5]);
            r_c[2] <= $signed(r_coef[8]);
        end
        if (en[2]) begin
            r_sx <= MW'(r_p[0]) + MW'(r_p[1]) + MW'(r_c[0]);
            r_sy <= MW'(r_p[2]) + MW'(r_p[3]) + MW'(r_c[1]);
            r_sz <= MW'(r_p[4]) + MW'(r_p[5]) + MW'(r_c[2]);
        end
        if (en[3]) begin
            r_ax  <= r_sx[MW-1] ? MW'(-r_sx) : MW'(r_sx);
            r_ay  <= r_sy[MW-1] ? MW'(-r_sy) : MW'(r_sy);
            r_az  <= r_sz[MW-1] ? MW'(-r_sz) : MW'(r_sz);
            r_nx3 <= r_sx[MW-1] ^ r_sz[MW-1];
            r_ny3 <= r_sy[MW-1] ^ r_sz[MW-1];
            r_zz3 <= (r_sz == '0);
        end
    end

    // divider trial subtracts, one quotient bit per stage
    always_comb begin
        for (int d = 1; d <= QB; d++) begin
            w_tz[d] = DW'(r_zm[d-1]) << (QB - d);
            w_gx[d] = r_rx[d-1] >= w_tz[d];
            w_gy[d] = r_ry[d-1] >= w_tz[d];
        end
    end

    // range guard then restoring division
    always_ff @(posedge i_clk) begin
        if (en[S_OVF]) begin
            r_rx[0] <= DW'(r_ax);
            r_ry[0] <= DW'(r_ay);
            r_zm[0] <= r_az;
            r_qx[0] <= '0;
            r_qy[0] <= '0;
            r_ox[0] <= DW'(r_ax) >= (DW'(r_az) << QB);
            r_oy[0] <= DW'(r_ay) >= (DW'(r_az) << QB);
            r_nx[0] <= r_nx3;
            r_ny[0] <= r_ny3;
            r_zz[0] <= r_zz3;
        end
        for (int d = 1; d <= QB; d++) begin
            if (en[S_OVF+d]) begin
                r_rx[d] <= w_gx[d] ? r_rx[d-1] - w_tz[d] : r_rx[d-1];
                r_ry[d] <= w_gy[d] ? r_ry[d-1] - w_tz[d] : r_ry[d-1];
                r_qx[d] <= r_qx[d-1] | (w_gx[d] ? (QB'(1) << (QB - d)) : '0);
                r_qy[d] <= r_qy[d-1] | (w_gy[d] ? (QB'(1) << (QB - d)) : '0);
                r_zm[d] <= r_zm[d-1];
                r_ox[d] <= r_ox[d-1];
                r_oy[d] <= r_oy[d-1];
                r_nx[d] <= r_nx[d-1];
                r_ny[d] <= r_ny[d-1];
                r_zz[d] <= r_zz[d-1];
            end
        end
    end

    // inside test and texel address
    always_comb begin
        w_wsat = (CW'(r_sw) > CW'(MAX_SIDE)) ? CW'(MAX_SIDE) : CW'(r_sw);
        w_hsat = (CW'(r_sh) > CW'(MAX_SIDE)) ? CW'(MAX_SIDE) : CW'(r_sh);
        // a negative quotient is inside only when it truncates to zero
        w_inx  = !r_ox[QB] && (r_nx[QB] ? (r_qx[QB] == '0 && w_wsat != '0)
                                        : (CW'(r_qx[QB]) < w_wsat));
        w_iny  = !r_oy[QB] && (r_ny[QB] ? (r_qy[QB] == '0 && w_hsat != '0)
                                        : (CW'(r_qy[QB]) < w_hsat));
        w_xv   = r_nx[QB] ? '0 : r_qx[QB];
        w_yv   = r_ny[QB] ? '0 : r_qy[QB];
        w_daddr   = AW'(w_yv) * AW'(w_wsat) + AW'(w_xv);
        w_slot_ok = 32'(r_side[S_ADR-1].slot) < 32'(DEPTH);
    end

    always_ff @(posedge i_clk) begin
        if (en[S_ADR]) begin
            if (r_side[S_ADR-1].cmd == ptbb_pkg::CMD_LOAD_TEXEL) begin
                r_addr <= AW'(r_side[S_ADR-1].slot);
                r_ahit <= w_slot_ok;
            end else begin
                r_addr <= w_daddr;
                r_ahit <= !r_zz[QB] && w_inx && w_iny;
            end
        end
    end

    // texel RAM: one read per advancing cycle plus a write for texel loads, in request order
    always_ff @(posedge i_clk) begin
        if (en[S_MEM]) begin
            r_rd   <= r_mem[r_addr];
            r_mhit <= r_ahit;
            if (r_vld[S_ADR] && r_ahit && r_side[S_ADR].cmd == ptbb_pkg::CMD_LOAD_TEXEL) begin
                r_mem[r_addr] <= r_side[S_ADR].pay;
            end
        end
    end

    // unpack texel and destination pixel to 8-bit channels (b, g, r, a)
    always_comb begin
        if (r_src_fmt == ptbb_pkg::FMT_RGB565) begin
            w_s[0] = {r_rd[4:0], 3'b000};
            w_s[1] = {r_rd[10:5], 2'b00};
            w_s[2] = {r_rd[15:11], 3'b000};
            w_s[3] = 8'hFF;
            w_key  = (r_rd[15:0] == '0);
        end else begin
            w_s[0] = r_rd[7:0];
            w_s[1] = r_rd[15:8];
            w_s[2] = r_rd[23:16];
            w_s[3] = (r_src_fmt == ptbb_pkg::FMT_ARGB8888) ? r_rd[31:24] : 8'hFF;
            w_key  = (r_rd[23:0] == '0);
        end
        if (r_dst_fmt == ptbb_pkg::FMT_RGB565) begin
            w_d[0] = {r_side[S_MEM].pay[4:0], 3'b000};
            w_d[1] = {r_side[S_MEM].pay[10:5], 2'b00};
            w_d[2] = {r_side[S_MEM].pay[15:11], 3'b000};
            w_d[3] = 8'h00;
        end else begin
            w_d[0] = r_side[S_MEM].pay[7:0];
            w_d[1] = r_side[S_MEM].pay[15:8];
            w_d[2] = r_side[S_MEM].pay[23:16];
            w_d[3] = r_side[S_MEM].pay[31:24];
        end
        w_we = r_mhit && !w_key && r_opacity != '0
            && r_src_fmt <= ptbb_pkg::FMT_ARGB8888 && r_dst_fmt <= ptbb_pkg::FMT_ARGB8888;
    end

    // decode, weight, mix
    always_ff @(posedge i_clk) begin
        if (en[S_DEC]) begin
            r_sc  <= w_s;
            r_dc  <= w_d;
            r_wp  <= 16'(w_s[3]) * 16'(r_opacity);
            r_dwe <= w_we;
        end
        if (en[S_WGT]) begin
            // alpha source over RGB565 scales the blend weight by source alpha unless opacity is 255
            r_wt  <= (r_dst_fmt == ptbb_pkg::FMT_RGB565 && r_opacity != 8'd255
                      && r_src_fmt == ptbb_pkg::FMT_ARGB8888) ?
                     ptbb_pkg::div255(r_wp) : r_opacity;
            r_sc2 <= r_sc;
            r_dc2 <= r_dc;
            r_wwe <= r_dwe;
        end
        if (en[S_MIX]) begin
            for (int c = 0; c < 4; c++) begin
                r_mx[c] <= 16'(r_sc2[c]) * 16'(r_wt)
                         + 16'(r_dc2[c]) * 16'(8'd255 - r_wt);
            end
            r_mwe <= r_wwe;
        end
    end

    // narrow and pack; weight 255 reproduces the source exactly
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_m[c] = ptbb_pkg::div255(r_mx[c]);
        end
        unique case (r_dst_fmt)
            ptbb_pkg::FMT_RGB565:   w_res = {16'h0000, w_m[2][7:3], w_m[1][7:2], w_m[0][7:3]};
            ptbb_pkg::FMT_RGB888:   w_res = {8'h00, w_m[2], w_m[1], w_m[0]};
            ptbb_pkg::FMT_ARGB8888: w_res = {w_m[3], w_m[2], w_m[1], w_m[0]};
            default:                w_res = '0;
        endcase
    end

    // output register; a skipped pixel returns the destination unchanged
    always_ff @(posedge i_clk) begin
        if (en[S_OUT]) begin
            r_opix <= r_mwe ? w_res : r_side[S_MIX].pay;
            r_owe  <= r_mwe;
        end
    end

    `PTBB_ASSERT_IMP(a_stall_full, i_clk, i_rst_n, r_vld[0] && !en[0],
        (&r_vld) && !i_m_axis_tready, "input held while pipeline has a free stage")
    `PTBB_ASSERT_NXT(a_accept_fill, i_clk, i_rst_n, acc,
        r_vld[0], "accepted request not captured")
    `PTBB_ASSERT_IMP(a_out_is_draw, i_clk, i_rst_n, o_m_axis_tvalid,
        r_side[S_OUT].cmd == ptbb_pkg::CMD_DRAW, "result from a non-draw request")

endmodule
